>>> sv/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants for the capture/compare timer.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;
    localparam int SEL_W  = 4;

    localparam logic [CNT_W-1:0] CNT_RESET = 16'hFFFC;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_PIN_A = 3'd1,
        OP_PIN_B = 3'd2,
        OP_READ  = 3'd3,
        OP_WRITE = 3'd4
    } t_op;

    localparam logic [SEL_W-1:0] SEL_CNT_HI  = 4'd0;
    localparam logic [SEL_W-1:0] SEL_CNT_LO  = 4'd1;
    localparam logic [SEL_W-1:0] SEL_ALT_HI  = 4'd2;
    localparam logic [SEL_W-1:0] SEL_ALT_LO  = 4'd3;
    localparam logic [SEL_W-1:0] SEL_CAPA_HI = 4'd4;
    localparam logic [SEL_W-1:0] SEL_CAPA_LO = 4'd5;
    localparam logic [SEL_W-1:0] SEL_CAPB_HI = 4'd6;
    localparam logic [SEL_W-1:0] SEL_CAPB_LO = 4'd7;
    localparam logic [SEL_W-1:0] SEL_CMP_HI  = 4'd8;
    localparam logic [SEL_W-1:0] SEL_CMP_LO  = 4'd9;
    localparam logic [SEL_W-1:0] SEL_STATUS  = 4'd10;

    // status flag bit positions
    localparam int FLG_CAPB = 0;
    localparam int FLG_OVF  = 1;
    localparam int FLG_CMP  = 2;
    localparam int FLG_CAPA = 3;

    // control register bit positions
    localparam int CTL_LEVEL    = 0;
    localparam int CTL_EDGE_A   = 1;
    localparam int CTL_EDGE_B   = 2;
    localparam int CTL_IE_CAPB  = 4;
    localparam int CTL_IE_OVF   = 5;
    localparam int CTL_IE_CMP   = 6;
    localparam int CTL_IE_CAPA  = 7;

    // inhibit bit positions
    localparam int INH_CAPA = 0;
    localparam int INH_CAPB = 1;
    localparam int INH_CMP  = 2;

    typedef struct packed {
        logic             vld;
        logic [BYTE_W-1:0] lo;
    } t_latch;

    typedef struct packed {
        logic [BYTE_W-1:0] write_data;
        logic [SEL_W-1:0]  reg_sel;
        logic              pin_level;
        t_op               op;
    } t_item;

    typedef struct packed {
        logic              compare_level;
        logic              compare_event;
        logic              irq;
        logic [BYTE_W-1:0] read_data;
    } t_result;

endpackage

>>> sv/capture_compare_timer.sv
// ----------------------------------------------------------------------------
// capture_compare_timer
// 16-bit free-running timer with two input captures and one output compare.
// ----------------------------------------------------------------------------
// Each transfer on the slave side is one item: a tick, a capture pin level,
// or a byte register read or write. Items are taken one per clock while the
// master side keeps up: an item is registered on entry, processed against
// the timer state once the output register can take its result, and its
// single result lands in that output register. The control register is
// written through its own channel and must only be written while no item is
// in flight.
module capture_compare_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [0] pin_level, [4:1] reg_sel, [12:5] write_data
    input  logic [2:0]  s_axis_tuser,  // [2:0] op
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] read_data, [8] irq, [9] compare_event,
                                       // [10] compare_level
    // control register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import cct_pkg::*;

    logic                r_in_vld;
    t_item               r_in;
    logic                r_out_vld;
    t_result             r_out;
    logic                w_adv;

    logic [BYTE_W-1:0]   r_ctl;
    logic [CNT_W-1:0]    r_cnt,  n_cnt;
    logic [CNT_W-1:0]    r_capa, n_capa;
    logic [CNT_W-1:0]    r_capb, n_capb;
    logic [CNT_W-1:0]    r_cmp,  n_cmp;
    logic [3:0]          r_flg,  n_flg;
    logic [3:0]          r_seen, n_seen;
    logic [1:0]          r_pins, n_pins;
    logic [2:0]          r_inh,  n_inh;
    t_latch              r_lat,  n_lat;
    t_latch              r_alt,  n_alt;
    t_result             n_res;

    logic [CNT_W-1:0]    w_cnt_inc;
    logic                w_hit_a, w_hit_b;

    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out};
    assign o_cfg_ready   = 1'b1;

    assign w_cnt_inc = r_cnt + 16'd1;
    assign w_hit_a = r_ctl[CTL_EDGE_A] ? (!r_pins[0] && r_in.pin_level)
                                       : (r_pins[0] && !r_in.pin_level);
    assign w_hit_b = r_ctl[CTL_EDGE_B] ? (!r_pins[1] && r_in.pin_level)
                                       : (r_pins[1] && !r_in.pin_level);

    always_comb begin
        n_cnt  = r_cnt;
        n_capa = r_capa;
        n_capb = r_capb;
        n_cmp  = r_cmp;
        n_flg  = r_flg;
        n_seen = r_seen;
        n_pins = r_pins;
        n_inh  = r_inh;
        n_lat  = r_lat;
        n_alt  = r_alt;
        n_res  = '0;
        unique case (r_in.op)
            OP_TICK: begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc == '0) begin
                    n_flg[FLG_OVF] = 1'b1;
                    if (r_ctl[CTL_IE_OVF]) n_res.irq = 1'b1;
                end
                if (w_cnt_inc == r_cmp && !r_inh[INH_CMP]) begin
                    n_flg[FLG_CMP]      = 1'b1;
                    n_res.compare_event = 1'b1;
                    n_res.compare_level = r_ctl[CTL_LEVEL];
                    if (r_ctl[CTL_IE_CMP]) n_res.irq = 1'b1;
                end
            end
            OP_PIN_A: begin
                n_pins[0] = r_in.pin_level;
                if (w_hit_a && !r_inh[INH_CAPA]) begin
                    n_capa         = w_cnt_inc;
                    n_flg[FLG_CAPA] = 1'b1;
                    if (r_ctl[CTL_IE_CAPA]) n_res.irq = 1'b1;
                end
            end
            OP_PIN_B: begin
                n_pins[1] = r_in.pin_level;
                if (w_hit_b && !r_inh[INH_CAPB]) begin
                    n_capb         = w_cnt_inc;
                    n_flg[FLG_CAPB] = 1'b1;
                    if (r_ctl[CTL_IE_CAPB]) n_res.irq = 1'b1;
                end
            end
            OP_READ: begin
                unique case (r_in.reg_sel)
                    SEL_CNT_HI: begin
                        if (!r_lat.vld) n_lat = '{vld: 1'b1, lo: r_cnt[7:0]};
                        n_res.read_data = r_cnt[15:8];
                    end
                    SEL_CNT_LO: begin
                        if (r_seen[FLG_OVF]) begin
                            n_flg[FLG_OVF]  = 1'b0;
                            n_seen[FLG_OVF] = 1'b0;
                        end
                        if (r_lat.vld) begin
                            n_res.read_data = r_lat.lo;
                            n_lat           = '0;
                        end else begin
                            n_res.read_data = r_cnt[7:0];
                        end
                    end
                    SEL_ALT_HI: begin
                        if (!r_alt.vld) n_alt = '{vld: 1'b1, lo: r_cnt[7:0]};
                        n_res.read_data = r_cnt[15:8];
                    end
                    SEL_ALT_LO: begin
                        if (r_alt.vld) begin
                            n_res.read_data = r_alt.lo;
                            n_alt           = '0;
                        end else begin
                            n_res.read_data = r_cnt[7:0];
                        end
                    end
                    SEL_CAPA_HI: begin
                        n_inh[INH_CAPA] = 1'b1;
                        n_res.read_data = r_capa[15:8];
                    end
                    SEL_CAPA_LO: begin
                        n_inh[INH_CAPA] = 1'b0;
                        if (r_seen[FLG_CAPA]) begin
                            n_flg[FLG_CAPA]  = 1'b0;
                            n_seen[FLG_CAPA] = 1'b0;
                        end
                        n_res.read_data = r_capa[7:0];
                    end
                    SEL_CAPB_HI: begin
                        n_inh[INH_CAPB] = 1'b1;
                        n_res.read_data = r_capb[15:8];
                    end
                    SEL_CAPB_LO: begin
                        n_inh[INH_CAPB] = 1'b0;
                        if (r_seen[FLG_CAPB]) begin
                            n_flg[FLG_CAPB]  = 1'b0;
                            n_seen[FLG_CAPB] = 1'b0;
                        end
                        n_res.read_data = r_capb[7:0];
                    end
                    SEL_CMP_HI: n_res.read_data = r_cmp[15:8];
                    SEL_CMP_LO: begin
                        if (r_seen[FLG_CMP]) begin
                            n_flg[FLG_CMP]  = 1'b0;
                            n_seen[FLG_CMP] = 1'b0;
                        end
                        n_res.read_data = r_cmp[7:0];
                    end
                    SEL_STATUS: begin
                        // arm every flag that is set now
                        n_seen          = r_flg;
                        n_res.read_data = {r_flg, 4'd0};
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                if (r_in.reg_sel == SEL_CMP_HI) begin
                    n_inh[INH_CMP] = 1'b1;
                    n_cmp[15:8]    = r_in.write_data;
                end else if (r_in.reg_sel == SEL_CMP_LO) begin
                    n_inh[INH_CMP] = 1'b0;
                    n_cmp[7:0]     = r_in.write_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctl     <= '0;
            r_cnt     <= CNT_RESET;
            r_capa    <= '0;
            r_capb    <= '0;
            r_cmp     <= '0;
            r_flg     <= '0;
            r_seen    <= '0;
            r_pins    <= '0;
            r_inh     <= '0;
            r_lat     <= '0;
            r_alt     <= '0;
        end else begin
            if (i_cfg_valid) r_ctl <= i_cfg_data;
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_cnt     <= n_cnt;
                r_capa    <= n_capa;
                r_capb    <= n_capb;
                r_cmp     <= n_cmp;
                r_flg     <= n_flg;
                r_seen    <= n_seen;
                r_pins    <= n_pins;
                r_inh     <= n_inh;
                r_lat     <= n_lat;
                r_alt     <= n_alt;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= '{write_data: s_axis_tdata[12:5], reg_sel: s_axis_tdata[4:1],
                      pin_level: s_axis_tdata[0], op: t_op'(s_axis_tuser)};
        end
        if (w_adv) r_out <= n_res;
    end

    // a result waiting on the master side is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> r_out_vld)
        else $error("pending result lost");

    // the counter moves only when a tick is processed
    a_cnt_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && r_in.op == OP_TICK) |=> $stable(r_cnt))
        else $error("counter moved without a tick");

    // writing compare high blocks matches until compare low is written
    a_cmp_inh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in.op == OP_WRITE && r_in.reg_sel == SEL_CMP_HI |=> r_inh[INH_CMP])
        else $error("compare inhibit not set");

    // a compare level is only driven together with a compare event
    a_lvl_evt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.compare_level |-> r_out.compare_event)
        else $error("compare level without event");

    // an armed flag is always one that is set
    a_seen_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen & ~r_flg) == 4'd0)
        else $error("armed flag not set");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capture/compare timer.
// ----------------------------------------------------------------------------
// A queue of timer items (ticks, pin levels, register reads and writes) feeds
// a stream driver. Every transfer it makes is run through a cycle-free timer
// model and the predicted result is queued. A monitor takes results from the
// master side and checks each one against the oldest prediction. The control
// register is rewritten between phases once the pipe is empty.
// ----------------------------------------------------------------------------
module tb;
    import cct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 95;
    localparam logic [OP_W-1:0]  OP_UNUSED = 3'd7;
    localparam logic [SEL_W-1:0] SEL_NONE  = 4'd15;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // [0] pin_level, [4:1] reg_sel, [12:5] write_data
    logic [2:0]  s_axis_tuser  = '0;  // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] read_data, [8] irq, [9] compare_event,
                                      // [10] compare_level
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;

    capture_compare_timer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timer model state
    logic [CNT_W-1:0]  tmr_cnt   = CNT_RESET;
    logic [CNT_W-1:0]  cap_a     = '0;
    logic [CNT_W-1:0]  cap_b     = '0;
    logic [CNT_W-1:0]  cmp_val   = '0;
    logic [3:0]        flags     = '0;
    logic [3:0]        armed     = '0;
    logic [1:0]        pins      = '0;   // bit0 pin A, bit1 pin B
    logic [2:0]        inhibit   = '0;
    t_latch            cnt_latch = '0;
    t_latch            alt_latch = '0;
    logic [BYTE_W-1:0] ctl_shadow = '0;

    t_item   pending_q[$];
    t_result timer_results_q[$];
    t_item   cur_item;

    logic [CNT_W-1:0] plan_cnt = CNT_RESET;  // count as it will stand after queued ticks
    bit   calm = 1'b0;
    int   items_queued, items_sent, results_seen, irqs_seen, matches_seen;
    int   mismatches, settings_written, quiet_cycles;

    function automatic logic rand_lvl();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [SEL_W-1:0] rand_sel();
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void clear_if_armed(input int f);
        if (armed[f]) begin
            flags[f] = 1'b0;
            armed[f] = 1'b0;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] timer_reg_read(input logic [SEL_W-1:0] sel);
        logic [BYTE_W-1:0] v;
        v = '0;
        case (sel)
            SEL_CNT_HI: begin
                if (!cnt_latch.vld) cnt_latch = '{1'b1, tmr_cnt[7:0]};
                v = tmr_cnt[15:8];
            end
            SEL_CNT_LO: begin
                clear_if_armed(FLG_OVF);
                if (cnt_latch.vld) begin
                    v = cnt_latch.lo;
                    cnt_latch = '0;
                end else begin
                    v = tmr_cnt[7:0];
                end
            end
            SEL_ALT_HI: begin
                if (!alt_latch.vld) alt_latch = '{1'b1, tmr_cnt[7:0]};
                v = tmr_cnt[15:8];
            end
            SEL_ALT_LO: begin
                if (alt_latch.vld) begin
                    v = alt_latch.lo;
                    alt_latch = '0;
                end else begin
                    v = tmr_cnt[7:0];
                end
            end
            SEL_CAPA_HI: begin
                inhibit[INH_CAPA] = 1'b1;
                v = cap_a[15:8];
            end
            SEL_CAPA_LO: begin
                inhibit[INH_CAPA] = 1'b0;
                clear_if_armed(FLG_CAPA);
                v = cap_a[7:0];
            end
            SEL_CAPB_HI: begin
                inhibit[INH_CAPB] = 1'b1;
                v = cap_b[15:8];
            end
            SEL_CAPB_LO: begin
                inhibit[INH_CAPB] = 1'b0;
                clear_if_armed(FLG_CAPB);
                v = cap_b[7:0];
            end
            SEL_CMP_HI: v = cmp_val[15:8];
            SEL_CMP_LO: begin
                clear_if_armed(FLG_CMP);
                v = cmp_val[7:0];
            end
            SEL_STATUS: begin
                armed = flags;
                v = {flags, 4'b0000};
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_result timer_step(input t_item it);
        t_result r;
        logic    old;
        logic    hit;
        r = '0;
        case (it.op)
            OP_TICK: begin
                tmr_cnt = tmr_cnt + 1'b1;
                if (tmr_cnt == '0) begin
                    flags[FLG_OVF] = 1'b1;
                    if (ctl_shadow[CTL_IE_OVF]) r.irq = 1'b1;
                end
                // a half-written compare value blocks the match
                if (tmr_cnt == cmp_val && !inhibit[INH_CMP]) begin
                    flags[FLG_CMP] = 1'b1;
                    r.compare_event = 1'b1;
                    r.compare_level = ctl_shadow[CTL_LEVEL];
                    if (ctl_shadow[CTL_IE_CMP]) r.irq = 1'b1;
                end
            end
            OP_PIN_A: begin
                old = pins[0];
                pins[0] = it.pin_level;
                hit = ctl_shadow[CTL_EDGE_A] ? (!old && it.pin_level) : (old && !it.pin_level);
                if (hit && !inhibit[INH_CAPA]) begin
                    cap_a = tmr_cnt + 1'b1;
                    flags[FLG_CAPA] = 1'b1;
                    if (ctl_shadow[CTL_IE_CAPA]) r.irq = 1'b1;
                end
            end
            OP_PIN_B: begin
                old = pins[1];
                pins[1] = it.pin_level;
                hit = ctl_shadow[CTL_EDGE_B] ? (!old && it.pin_level) : (old && !it.pin_level);
                if (hit && !inhibit[INH_CAPB]) begin
                    cap_b = tmr_cnt + 1'b1;
                    flags[FLG_CAPB] = 1'b1;
                    if (ctl_shadow[CTL_IE_CAPB]) r.irq = 1'b1;
                end
            end
            OP_READ: r.read_data = timer_reg_read(it.reg_sel);
            OP_WRITE: begin
                if (it.reg_sel == SEL_CMP_HI) begin
                    inhibit[INH_CMP] = 1'b1;
                    cmp_val[15:8] = it.write_data;
                end else if (it.reg_sel == SEL_CMP_LO) begin
                    inhibit[INH_CMP] = 1'b0;
                    cmp_val[7:0] = it.write_data;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op_bits, input logic lvl,
                              input logic [SEL_W-1:0] sel, input logic [BYTE_W-1:0] data);
        t_item it;
        it.op         = t_op'(op_bits);
        it.pin_level  = lvl;
        it.reg_sel    = sel;
        it.write_data = data;
        pending_q.push_back(it);
        items_queued++;
        if (op_bits == OP_TICK) plan_cnt = plan_cnt + 1'b1;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_item(OP_TICK, rand_lvl(), rand_sel(), rand_byte());
    endtask

    // one short sequence: mostly the access patterns software would use
    task automatic queue_burst();
        logic [CNT_W-1:0] val;
        logic [SEL_W-1:0] sel;
        case ($urandom_range(9))
            0, 1: queue_ticks($urandom_range(1, 8));
            2: begin
                queue_item(OP_PIN_A, 1'b1, rand_sel(), rand_byte());
                queue_ticks($urandom_range(0, 2));
                queue_item(OP_PIN_A, 1'b0, rand_sel(), rand_byte());
            end
            3: queue_item($urandom_range(1) ? OP_PIN_A : OP_PIN_B, rand_lvl(),
                          rand_sel(), rand_byte());
            4: begin
                queue_item(OP_PIN_B, 1'b1, rand_sel(), rand_byte());
                queue_ticks($urandom_range(0, 2));
                queue_item(OP_PIN_B, 1'b0, rand_sel(), rand_byte());
            end
            5: begin
                // high/low pair, sometimes with ticks or a capture in between
                sel = SEL_CNT_HI + 4'(2 * $urandom_range(4));
                queue_item(OP_READ, rand_lvl(), sel, rand_byte());
                if ($urandom_range(1)) queue_ticks($urandom_range(1, 3));
                if ($urandom_range(3) == 0)
                    queue_item($urandom_range(1) ? OP_PIN_A : OP_PIN_B, rand_lvl(),
                               rand_sel(), rand_byte());
                queue_item(OP_READ, rand_lvl(), sel + 1'b1, rand_byte());
            end
            6: begin
                // flag clearing: status read, then a low byte
                queue_item(OP_READ, rand_lvl(), SEL_STATUS, rand_byte());
                if ($urandom_range(2) == 0) queue_ticks($urandom_range(1, 3));
                case ($urandom_range(4))
                    0: sel = SEL_CNT_LO;
                    1: sel = SEL_CAPA_LO;
                    2: sel = SEL_CMP_LO;
                    3: sel = SEL_CAPB_LO;
                    default: sel = SEL_ALT_LO;
                endcase
                queue_item(OP_READ, rand_lvl(), sel, rand_byte());
            end
            7: begin
                // compare set just ahead of the count so that it may match
                val = plan_cnt + 16'($urandom_range(1, 6));
                queue_item(OP_WRITE, rand_lvl(), SEL_CMP_HI, val[15:8]);
                if ($urandom_range(3) == 0) queue_ticks($urandom_range(1, 6));
                queue_item(OP_WRITE, rand_lvl(), SEL_CMP_LO, val[7:0]);
                queue_ticks($urandom_range(1, 8));
            end
            default: queue_item(3'($urandom_range(7)), rand_lvl(), rand_sel(), rand_byte());
        endcase
    endtask

    task automatic queue_random(input int n);
        int stop_at;
        stop_at = items_queued + n;
        while (items_queued < stop_at) queue_burst();
    endtask

    // sender holds until all results are back and the pipe has settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || timer_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_control(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ctl_shadow = v;
        settings_written++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            timer_results_q.push_back(timer_step(cur_item));
            items_sent++;
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
                cur_item = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b000, cur_item.write_data, cur_item.reg_sel,
                                  cur_item.pin_level};
                s_axis_tuser  <= cur_item.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[10:0];
            results_seen++;
            if (got.irq) irqs_seen++;
            if (got.compare_event) matches_seen++;
            if (timer_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: result %0h with nothing expected", $time, m_axis_tdata);
            end else begin
                want = timer_results_q.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("irq", 8'(want.irq), 8'(got.irq));
                check_field("compare_event", 8'(want.compare_event), 8'(got.compare_event));
                check_field("compare_level", 8'(want.compare_level), 8'(got.compare_level));
            end
        end
        m_axis_tready <= i_rst_n && (calm || $urandom_range(99) >= 30);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, timer_results_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] ctl_val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: all interrupts on, rising edges, compare level high
        write_control(8'hFF);
        queue_item(OP_WRITE, 1'b0, SEL_CMP_HI, 8'h00);   // half-written compare
        queue_item(OP_TICK, 1'b0, SEL_CNT_HI, 8'h00);
        queue_item(OP_WRITE, 1'b0, SEL_CMP_LO, 8'h00);
        queue_ticks(3);                                  // wrap, overflow and match at zero
        queue_item(OP_PIN_A, 1'b1, SEL_CNT_HI, 8'h00);
        queue_item(OP_PIN_B, 1'b1, SEL_CNT_HI, 8'h00);
        queue_item(OP_PIN_B, 1'b0, SEL_CNT_HI, 8'h00);   // wrong edge
        queue_item(OP_READ, 1'b0, SEL_STATUS, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CNT_HI, 8'h00);
        queue_ticks(1);
        queue_item(OP_READ, 1'b0, SEL_CNT_LO, 8'h00);    // latched byte, overflow cleared
        queue_item(OP_READ, 1'b0, SEL_ALT_HI, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_ALT_LO, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CAPA_HI, 8'h00);   // capture A held off
        queue_item(OP_PIN_A, 1'b0, SEL_CNT_HI, 8'h00);
        queue_item(OP_PIN_A, 1'b1, SEL_CNT_HI, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CAPA_LO, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CAPB_HI, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CAPB_LO, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CMP_HI, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_CMP_LO, 8'h00);
        queue_item(OP_READ, 1'b0, SEL_STATUS, 8'h00);
        queue_item(OP_READ, 1'b1, SEL_NONE, 8'hFF);
        queue_item(OP_WRITE, 1'b1, SEL_ALT_LO, 8'hFF);   // not a compare half: ignored
        queue_item(OP_UNUSED, 1'b1, SEL_NONE, 8'hFF);
        queue_item(OP_WRITE, 1'b1, SEL_CMP_HI, 8'hFF);
        queue_item(OP_WRITE, 1'b1, SEL_CMP_LO, 8'hFF);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: ctl_val = 8'h00;
                1: ctl_val = 8'hFF;
                default: ctl_val = 8'($urandom_range(255));
            endcase
            calm = (ph == 3);
            write_control(ctl_val);
            queue_random(PHASE_ITEMS / 2);
            if (ph == 2) wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end
        calm = 1'b0;

        $display("Sent %0d timer items over %0d control settings, checked %0d results",
                 items_sent, settings_written, results_seen);
        $display("Results with interrupt: %0d, compare matches: %0d, mismatches: %0d",
                 irqs_seen, matches_seen, mismatches);
        if (mismatches == 0 && timer_results_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/cct_pkg.sv
sv/capture_compare_timer.sv
dv/tb.sv
